/* rtl/core/ptf_pkg.sv */
// Package for the palette tint and fade block: item codes, register indexes,
// sequencer states, mood gains and reset values.
// No dependencies; the interfaces and the top level import it.
package ptf_pkg;

  localparam int LEVEL_FRACTION_BITS_DEF = 16;

  localparam int CHAN_BITS      = 8;
  localparam int GAIN_BITS      = 17;
  localparam int GAIN_SHIFT     = 16;
  localparam int MOOD_AGE_BITS  = 24;
  localparam int FADE_AGE_BITS  = 17;
  localparam int FADE_LEN_BITS  = 16;
  localparam int ALPHA_BITS     = 17;

  localparam logic [CHAN_BITS-1:0]     CHAN_MAX          = 8'd255;
  localparam logic [MOOD_AGE_BITS-1:0] MOOD_INTERVAL_RST = 24'd60000;
  localparam logic [FADE_LEN_BITS-1:0] ENTER_FADE_RST    = 16'd2000;

  typedef enum logic [1:0] {
    MOOD_MORNING,
    MOOD_AFTERNOON,
    MOOD_EVENING,
    MOOD_NIGHT
  } mood_t;

  typedef enum logic [2:0] {
    FUNC_TICK,
    FUNC_ENTER,
    FUNC_EXIT,
    FUNC_START_FADE,
    FUNC_PIXEL
  } func_t;

  typedef enum logic [1:0] {
    REG_ENABLE,
    REG_MOOD_INTERVAL,
    REG_ENTER_FADE
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_DIV,
    S_SQUARE,
    S_CUBE,
    S_LEVEL,
    S_GAIN,
    S_SAT,
    S_FADE,
    S_STORE,
    S_DONE
  } state_t;

  // Q.16 gain of one channel (0 red, 1 green, 2 blue) in one mood
  function automatic logic [GAIN_BITS-1:0] mood_gain(mood_t m, logic [1:0] ch);
    logic [GAIN_BITS-1:0] g;
    g = 17'd65536;
    case (m)
      MOOD_MORNING: begin
        case (ch)
          2'd0:    g = 17'd72090;
          2'd1:    g = 17'd68813;
          default: g = 17'd75366;
        endcase
      end
      MOOD_EVENING: begin
        case (ch)
          2'd0:    g = 17'd78643;
          2'd1:    g = 17'd72090;
          default: g = 17'd52429;
        endcase
      end
      MOOD_NIGHT: begin
        case (ch)
          2'd0:    g = 17'd45875;
          2'd1:    g = 17'd45875;
          default: g = 17'd58982;
        endcase
      end
      default: g = 17'd65536;
    endcase
    return g;
  endfunction

endpackage

/* rtl/core/ptf_if.sv */
// Valid/ready channel interfaces for the palette tint and fade block:
// the request item (event or pixel) and the result item.
// Depends on ptf_pkg for the field widths.
interface ptf_req_if
  import ptf_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               func;
  logic                     fade_in;
  logic [FADE_LEN_BITS-1:0] fade_duration;
  logic [CHAN_BITS-1:0]     red_in;
  logic [CHAN_BITS-1:0]     green_in;
  logic [CHAN_BITS-1:0]     blue_in;

  modport source (output valid, func, fade_in, fade_duration, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, func, fade_in, fade_duration, red_in, green_in, blue_in,
                output ready);
endinterface

interface ptf_rsp_if
  import ptf_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CHAN_BITS-1:0]  red_out;
  logic [CHAN_BITS-1:0]  green_out;
  logic [CHAN_BITS-1:0]  blue_out;
  logic [1:0]            mood;
  logic                  fading;
  logic [ALPHA_BITS-1:0] alpha;

  modport source (output valid, red_out, green_out, blue_out, mood, fading, alpha,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, mood, fading, alpha,
                output ready);
endinterface

/* rtl/core/palette_tint_and_fade.sv */
// Path: events, ticks and pixels out of scene or disabled go straight from execute to done;
// an in-scene tick checks mood and fade, and one that moves a fade adds a one-bit restoring
// divide, square, cube, level; a pixel runs gain and saturate per channel (fade, store too
// while a fade runs). One item at a time; the next is taken while a result waits.
// Reset: synchronous, active high; registers return to enable on, 60000 ms interval, 2000 ms
// enter fade, afternoon mood, out of scene, no fade running.
module palette_tint_and_fade
  import ptf_pkg::*;
#(
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ptf_req_if.sink     req,
  ptf_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F  = LEVEL_FRACTION_BITS;
  localparam int LW = F + 1;                                     // level, 0..ONE
  localparam int MA = F;                                         // multiplier operand A
  localparam int MB = (F + 2 > GAIN_BITS) ? F + 2 : GAIN_BITS;   // multiplier operand B
  localparam int PW = MA + MB;
  localparam int CW = $clog2(F);
  localparam logic [LW-1:0] LVL_ONE = {1'b1, {F{1'b0}}};
  localparam logic [CW-1:0] DIV_LAST = CW'(F - 1);

  // Configuration registers
  logic                     enable;
  logic [MOOD_AGE_BITS-1:0] mood_interval;
  logic [FADE_LEN_BITS-1:0] enter_fade;

  // Architectural state
  mood_t                    mood_now;
  logic [MOOD_AGE_BITS-1:0] mood_age;
  logic                     in_scene;
  logic                     fade_running;
  logic                     fade_dir_in;
  logic [FADE_AGE_BITS-1:0] fade_age;
  logic [FADE_LEN_BITS-1:0] fade_length;
  logic [LW-1:0]            fade_level;

  // Sequencer and working registers
  state_t                   state, state_next;
  logic [2:0]               op;
  logic                     op_dir;
  logic [FADE_LEN_BITS-1:0] op_dur;
  logic [CHAN_BITS-1:0]     chan_r, chan_g, chan_b;
  logic [1:0]               ch;
  logic [FADE_LEN_BITS-1:0] rem;
  logic [F-1:0]             quo;
  logic [CW-1:0]            div_cnt;
  logic [PW-1:0]            prod;
  logic                     rsp_valid;

  // Sequencer outputs
  logic          in_ready;
  logic          load_rsp;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;

  // Helpers
  logic                     cfg_wr;
  logic [CHAN_BITS-1:0]     chan_sel;
  logic [FADE_LEN_BITS:0]   rem_sh;
  logic                     rem_ge;
  logic                     fade_due;
  logic [MB-1:0]            t_val;
  logic [F+1:0]             s_val;
  logic [LW-1:0]            s_clip;
  logic                     gain_hi;
  logic [CHAN_BITS-1:0]     gain_sat;
  logic [LW-1:0]            alpha_full;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ENABLE:        prdata = {31'd0, enable};
      REG_MOOD_INTERVAL: prdata = {8'd0, mood_interval};
      REG_ENTER_FADE:    prdata = {16'd0, enter_fade};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    case (ch)
      2'd0:    chan_sel = chan_r;
      2'd1:    chan_sel = chan_g;
      default: chan_sel = chan_b;
    endcase
  end

  // Restoring divide step: remainder stays below the fade length
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, fade_length};
  assign fade_due = fade_age >= {1'b0, fade_length};

  // Smoothstep pieces: t = 3*ONE - 2p, s = (p2 * t) >> F clamped to ONE
  assign t_val  = (MB'(3) << F) - (MB'(quo) << 1);
  assign s_val  = prod[F +: F + 2];
  assign s_clip = (s_val > (F + 2)'(LVL_ONE)) ? LVL_ONE : s_val[LW-1:0];

  // Gain result: (c * gain) >> 16, saturated at full scale
  assign gain_hi  = |prod[PW-1:GAIN_SHIFT+CHAN_BITS];
  assign gain_sat = gain_hi ? CHAN_MAX : prod[GAIN_SHIFT +: CHAN_BITS];

  assign alpha_full = fade_running ? fade_level : (in_scene ? LVL_ONE : '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (enable && in_scene) begin
          case (op)
            FUNC_TICK:  state_next = S_CHECK;
            FUNC_PIXEL: state_next = S_GAIN;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        state_next = (fade_running && !fade_due) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_cnt == '0) state_next = S_SQUARE;
      end
      S_SQUARE: state_next = S_CUBE;
      S_CUBE:   state_next = S_LEVEL;
      S_LEVEL:  state_next = S_DONE;
      S_GAIN:   state_next = S_SAT;
      S_SAT: begin
        if (fade_running)  state_next = S_FADE;
        else if (ch == 2'd2) state_next = S_DONE;
        else               state_next = S_GAIN;
      end
      S_FADE:   state_next = S_STORE;
      S_STORE: begin
        state_next = (ch == 2'd2) ? S_DONE : S_GAIN;
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and the shared multiplier's operands
  always_comb begin
    in_ready = 1'b0;
    load_rsp = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_SQUARE: begin
        mul_a = quo;
        mul_b = MB'(quo);
      end
      S_CUBE: begin
        mul_a = prod[F +: F];
        mul_b = t_val;
      end
      S_GAIN: begin
        mul_a = MA'(chan_sel);
        mul_b = MB'(mood_gain(mood_now, ch));
      end
      S_FADE: begin
        mul_a = MA'(chan_sel);
        mul_b = MB'(fade_level);
      end
      S_DONE:   load_rsp = !rsp_valid || rsp.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};
  end

  // Working registers without reset
  always_ff @(posedge clk) begin
    if (in_ready && req.valid) begin
      op     <= req.func;
      op_dir <= req.fade_in;
      op_dur <= req.fade_duration;
      chan_r <= req.red_in;
      chan_g <= req.green_in;
      chan_b <= req.blue_in;
      ch     <= 2'd0;
    end
    case (state)
      S_CHECK: begin
        rem     <= fade_age[FADE_LEN_BITS-1:0];
        quo     <= '0;
        div_cnt <= DIV_LAST;
      end
      S_DIV: begin
        rem     <= rem_ge ? FADE_LEN_BITS'(rem_sh - {1'b0, fade_length})
                          : rem_sh[FADE_LEN_BITS-1:0];
        quo     <= {quo[F-2:0], rem_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      S_SAT, S_STORE: begin
        // write back the finished step of this channel, advance unless a fade step follows
        case (ch)
          2'd0:    chan_r <= (state == S_SAT) ? gain_sat : prod[F +: CHAN_BITS];
          2'd1:    chan_g <= (state == S_SAT) ? gain_sat : prod[F +: CHAN_BITS];
          default: chan_b <= (state == S_SAT) ? gain_sat : prod[F +: CHAN_BITS];
        endcase
        if (state == S_STORE || !fade_running) ch <= ch + 2'd1;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  // Architectural state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      mood_interval <= MOOD_INTERVAL_RST;
      enter_fade    <= ENTER_FADE_RST;
      mood_now      <= MOOD_AFTERNOON;
      mood_age      <= '0;
      in_scene      <= 1'b0;
      fade_running  <= 1'b0;
      fade_dir_in   <= 1'b0;
      fade_age      <= '0;
      fade_length   <= '0;
      fade_level    <= '0;
    end else begin
      case (state)
        S_EXEC: begin
          if (enable) begin
            case (op)
              FUNC_TICK: begin
                // time advances in or out of the scene
                if (mood_age != '1) mood_age <= mood_age + 1'b1;
                if (fade_running && fade_age != '1) fade_age <= fade_age + 1'b1;
              end
              FUNC_ENTER: begin
                in_scene     <= 1'b1;
                fade_running <= 1'b1;
                fade_dir_in  <= 1'b1;
                fade_age     <= '0;
                fade_length  <= enter_fade;
                fade_level   <= '0;
              end
              FUNC_EXIT: begin
                in_scene <= 1'b0;
              end
              FUNC_START_FADE: begin
                fade_running <= 1'b1;
                fade_dir_in  <= op_dir;
                fade_age     <= '0;
                fade_length  <= op_dur;
                fade_level   <= op_dir ? '0 : LVL_ONE;
              end
              default: begin
                fade_level <= fade_level;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (mood_age >= mood_interval) begin
            mood_now <= mood_t'(mood_now + 2'd1);
            mood_age <= '0;
          end
          if (fade_running && fade_due) begin
            fade_running <= 1'b0;
            fade_level   <= fade_dir_in ? LVL_ONE : '0;
          end
        end
        S_LEVEL: begin
          fade_level <= fade_dir_in ? s_clip : LW'(LVL_ONE - s_clip);
        end
        default: begin
          fade_level <= fade_level;
        end
      endcase

      // register writes come last so that they win
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_ENABLE: begin
            enable <= pwdata[0];
            if (!pwdata[0]) begin
              fade_running <= 1'b0;
              in_scene     <= 1'b0;
            end
          end
          REG_MOOD_INTERVAL: mood_interval <= pwdata[MOOD_AGE_BITS-1:0];
          REG_ENTER_FADE:    enter_fade    <= pwdata[FADE_LEN_BITS-1:0];
          default:           enable        <= enable;
        endcase
      end
    end
  end

  // Result register: hold until taken, load the next as the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.red_out   <= chan_r;
      rsp.green_out <= chan_g;
      rsp.blue_out  <= chan_b;
      rsp.mood      <= mood_now;
      rsp.fading    <= fade_running;
      rsp.alpha     <= ALPHA_BITS'(alpha_full);
    end
  end

  assign rsp.valid = rsp_valid;

  // Checks
  assert property (@(posedge clk) disable iff (rst) fade_level <= LVL_ONE)
    else $error("fade level above full scale");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < fade_length))
    else $error("divider remainder not below fade length");

  assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[3:2] == REG_ENABLE && !pwdata[0]) |=> (!fade_running && !in_scene))
    else $error("disable did not clear fade and scene");

  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(mood_now)) |-> ($past(state) == S_CHECK))
    else $error("mood changed outside a tick check");

endmodule
